FILE: src/ordered_id_list_engine_defines.svh
// Assertion macros shared by the ordered id list engine.
// Each macro expects signals named clock and reset in the calling module.
`ifndef ORDERED_ID_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ID_LIST_ENGINE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define OIDL_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define OIDL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define OIDL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/oidl_pkg.sv
`timescale 1ns / 1ps

package oidl_pkg;

   localparam int OIDL_CAPACITY = 16;
   localparam int OIDL_ID_W     = 32;

   typedef enum logic [1:0] {
      REQ_ADD_FRONT = 2'd0,
      REQ_ADD_BACK  = 2'd1,
      REQ_REMOVE    = 2'd2,
      REQ_LIST      = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_ENTRY     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_SHIFT,
      FSM_LIST
   } fsm_state_type;

endpackage

FILE: src/oidl_ram.sv
`timescale 1ns / 1ps

module oidl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The read register holds its value while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ordered_id_list_engine.sv
`timescale 1ns / 1ps

// Ordered id list engine: holds up to CAPACITY signed 32-bit ids in one
// circular RAM, front first, with a head pointer and a fill count in
// registers. An add at the front or back and every full or empty answer
// are answered from the idle state. A remove reads one entry per cycle
// from the front until it matches, then moves each later entry down one
// place, and requests stall until it answers. A list streams one result
// per cycle while the result side keeps up, each entry passing through
// the RAM read register first. The single read port of the RAM sets
// this pace. Results leave through an output register, and a new request
// is taken in the idle state once that register is empty or in the
// cycle in which its result is accepted; reset needs no clearing pass.

module ordered_id_list_engine
   import oidl_pkg::*;
#(
   parameter int CAPACITY = OIDL_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic signed [31:0]   req_bunny_id,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic signed [31:0]   rsp_entry_id,
   output logic                 rsp_last
);

`include "ordered_id_list_engine_defines.svh"

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // Position offset from the head, wrapped once around the ring.
   function automatic logic [PW-1:0] phys_addr(input logic [PW-1:0] base,
                                                input logic [CW-1:0] ofs);
      logic [CW:0] sum;
      sum = {{(CW + 1 - PW){1'b0}}, base} + {1'b0, ofs};
      if (sum >= (CW + 1)'(CAPACITY)) begin
         sum = sum - (CW + 1)'(CAPACITY);
      end
      return sum[PW-1:0];
   endfunction

   fsm_state_type state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] rd_pos_ff, rd_pos_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [OIDL_ID_W-1:0] key_ff, key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [OIDL_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          out_free;
   logic          accept;
   logic          full;
   logic          empty;
   logic          more;
   logic          rd_match;
   logic          at_last;
   logic          emit;
   logic          add_ok;
   logic          shift_vld;
   logic [CW-1:0] last_pos;
   logic [PW-1:0] head_dec;
   req_kind_type  kind;

   logic                 ram_wr_en;
   logic [PW-1:0]        ram_wr_addr;
   logic [OIDL_ID_W-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [PW-1:0]        ram_rd_addr;
   logic [OIDL_ID_W-1:0] ram_rd_data;

   oidl_ram #(
      .WIDTH (OIDL_ID_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != FSM_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign kind      = req_kind_type'(req_type);
   assign full      = (count_ff == CAP_C);
   assign empty     = (count_ff == '0);
   assign more      = (pos_ff < count_ff);
   assign last_pos  = count_ff - CW'(1);
   assign at_last   = (rd_pos_ff == last_pos);
   assign rd_match  = (ram_rd_data == key_ff);
   assign head_dec  = (head_ff == '0) ? PW'(CAPACITY - 1) : head_ff - PW'(1);
   assign add_ok    = accept && !full && (kind == REQ_ADD_FRONT || kind == REQ_ADD_BACK);
   assign shift_vld = (state_ff == FSM_SHIFT) && rd_vld_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept && !empty) begin
               if (kind == REQ_REMOVE) begin
                  state_in = FSM_SEARCH;
               end else if (kind == REQ_LIST) begin
                  state_in = FSM_LIST;
               end
            end
         end
         FSM_SEARCH: begin
            if (rd_vld_ff && rd_match) begin
               state_in = FSM_SHIFT;
            end else if (rd_vld_ff && at_last && out_free) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_SHIFT: begin
            if (!more && !rd_vld_ff && out_free) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_LIST: begin
            if (rd_vld_ff && at_last && out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Memory accesses, pointers and results.
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rd_pos_in     = rd_pos_ff;
      rd_vld_in     = rd_vld_ff;
      key_in        = key_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = phys_addr(head_ff, count_ff);
      ram_wr_data   = req_bunny_id;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = phys_addr(head_ff, pos_ff);
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               key_in    = req_bunny_id;
               pos_in    = '0;
               rd_vld_in = 1'b0;
               unique case (kind) inside
                  REQ_ADD_FRONT, REQ_ADD_BACK: begin
                     emit        = 1'b1;
                     rsp_id_in   = '0;
                     rsp_last_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_ADDED;
                        ram_wr_en     = 1'b1;
                        count_in      = count_ff + CW'(1);
                        if (kind == REQ_ADD_FRONT) begin
                           head_in     = head_dec;
                           ram_wr_addr = head_dec;
                        end
                     end
                  end
                  REQ_REMOVE, REQ_LIST: begin
                     if (empty) begin
                        emit          = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_id_in     = '0;
                        rsp_last_in   = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         FSM_SEARCH: begin
            ram_rd_en = more;
            if (more) begin
               pos_in    = pos_ff + CW'(1);
               rd_pos_in = pos_ff;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff && rd_match) begin
               // Later entries move down over the match, starting just past it.
               pos_in    = rd_pos_ff + CW'(1);
               rd_vld_in = 1'b0;
            end else if (rd_vld_ff && at_last && out_free) begin
               emit          = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               rd_vld_in     = 1'b0;
            end
         end
         FSM_SHIFT: begin
            ram_rd_en = more;
            rd_vld_in = more;
            if (more) begin
               pos_in    = pos_ff + CW'(1);
               rd_pos_in = pos_ff;
            end
            if (rd_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = phys_addr(head_ff, rd_pos_ff - CW'(1));
               ram_wr_data = ram_rd_data;
            end
            if (!more && !rd_vld_ff && out_free) begin
               emit          = 1'b1;
               rsp_status_in = ST_REMOVED;
               rsp_id_in     = key_ff;
               rsp_last_in   = 1'b1;
               count_in      = count_ff - CW'(1);
            end
         end
         FSM_LIST: begin
            // The read register holds while a listed entry waits for the output.
            ram_rd_en = more && (!rd_vld_ff || out_free);
            if (rd_vld_ff && out_free) begin
               emit          = 1'b1;
               rsp_status_in = ST_ENTRY;
               rsp_id_in     = ram_rd_data;
               rsp_last_in   = at_last;
               rd_vld_in     = 1'b0;
            end
            if (ram_rd_en) begin
               pos_in    = pos_ff + CW'(1);
               rd_pos_in = pos_ff;
               rd_vld_in = 1'b1;
            end
         end
         default: ;
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      rd_pos_ff     <= rd_pos_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_entry_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

   `OIDL_ASSERT_ALWAYS(a_count_bound, count_ff <= CAP_C, "fill count exceeds capacity")
   `OIDL_ASSERT_NEXT(a_add_grows, add_ok, count_ff == $past(count_ff) + CW'(1), "add not counted")
   `OIDL_ASSERT_SAME(a_read_in_list, rd_vld_ff, rd_pos_ff < count_ff, "read outside the list")
   `OIDL_ASSERT_SAME(a_shift_source, shift_vld, rd_pos_ff != '0, "shift from the front")

endmodule
